// File: design/sli_pkg.sv
// Shared types and codes for the sorted list block.
// Used by sli_ctrl, sli_dpath and sorted_list_insert_delete.
package sli_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_DUMP   = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_LISTED    = 3'd5
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_t;

  typedef struct packed {
    logic insert;
    logic remove;
    logic dump_empty;
    logic dump_step;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic count_zero;
    logic dump_last;
  } sts_t;

endpackage

// File: design/sli_ctrl.sv
// Controller for the sorted list: decodes input words and sequences dumps.
// Depends on sli_pkg; drives commands into sli_dpath.
module sli_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sli_pkg::FUNC_W-1:0]        in_func,
  input  sli_pkg::sts_t                     sts,
  output sli_pkg::cmd_t                     cmd
);

  sli_pkg::state_t state_r;
  sli_pkg::state_t state_nxt;
  logic            accept;

  assign accept = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sli_pkg::S_IDLE: begin
        if (accept && in_func == sli_pkg::FUNC_DUMP && !sts.count_zero) begin
          state_nxt = sli_pkg::S_DUMP;
        end
      end
      sli_pkg::S_DUMP: begin
        if (sts.slot_free && sts.dump_last) begin
          state_nxt = sli_pkg::S_IDLE;
        end
      end
      default: state_nxt = sli_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      sli_pkg::S_IDLE: begin
        in_tready = sts.slot_free;
        if (accept) begin
          case (in_func)
            sli_pkg::FUNC_INSERT: cmd.insert     = 1'b1;
            sli_pkg::FUNC_DELETE: cmd.remove     = 1'b1;
            sli_pkg::FUNC_DUMP:   cmd.dump_empty = sts.count_zero;
            default:              cmd            = '0;
          endcase
        end
      end
      sli_pkg::S_DUMP: begin
        cmd.dump_step = sts.slot_free;
      end
      default: begin
        in_tready = 1'b0;
        cmd       = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sli_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_ready_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sli_pkg::S_DUMP |-> !in_tready)
    else $error("input ready during dump");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.insert, cmd.remove, cmd.dump_empty, cmd.dump_step}))
    else $error("more than one command");
  a_dump_enter: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_func == sli_pkg::FUNC_DUMP && !sts.count_zero |=> state_r == sli_pkg::S_DUMP)
    else $error("dump not entered");
`endif

endmodule

// File: design/sli_dpath.sv
// Datapath for the sorted list: row of compare-and-shift cells, count, result register.
// Depends on sli_pkg; commanded by sli_ctrl.
module sli_dpath #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [sli_pkg::VALUE_W-1:0] in_value,
  input  sli_pkg::cmd_t                     cmd,
  output sli_pkg::sts_t                     sts,
  input  logic                              out_tready,
  output logic                              out_valid,
  output logic [sli_pkg::STATUS_W-1:0]      out_status,
  output logic signed [sli_pkg::VALUE_W-1:0] out_element,
  output logic [sli_pkg::OCC_W-1:0]         out_occ,
  output logic                              out_last
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);

  logic signed [sli_pkg::VALUE_W-1:0] cells_r   [CAPACITY];
  logic signed [sli_pkg::VALUE_W-1:0] cells_nxt [CAPACITY];
  logic [CW-1:0]                      count_r;
  logic [CW-1:0]                      count_nxt;
  logic [IW-1:0]                      idx_r;
  logic [IW-1:0]                      idx_nxt;
  logic                               out_valid_r;
  logic                               out_valid_nxt;
  logic [sli_pkg::STATUS_W-1:0]       status_r;
  logic [sli_pkg::STATUS_W-1:0]       status_nxt;
  logic signed [sli_pkg::VALUE_W-1:0] element_r;
  logic signed [sli_pkg::VALUE_W-1:0] element_nxt;
  logic [CW-1:0]                      occ_r;
  logic [CW-1:0]                      occ_nxt;
  logic                               last_r;
  logic                               last_nxt;
  logic [CAPACITY-1:0]                lt;
  logic [CAPACITY-1:0]                eq;
  logic [CAPACITY-1:0]                hit_seen;
  logic                               full;
  logic                               found;
  logic                               dump_last;
  logic [CW-1:0]                      count_m1;
  logic [CW+sli_pkg::OCC_W-1:0]       occ_ext;

  assign full      = count_r >= CW'(CAPACITY);
  assign count_m1  = count_r - CW'(1);
  assign dump_last = CW'(idx_r) == count_m1;
  assign found     = hit_seen[CAPACITY-1];

  assign sts.slot_free  = !out_valid_r || out_tready;
  assign sts.count_zero = count_r == '0;
  assign sts.dump_last  = dump_last;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt[i] = (CW'(i) < count_r) && (cells_r[i] < in_value);
      eq[i] = (CW'(i) < count_r) && (cells_r[i] == in_value);
    end
    hit_seen[0] = eq[0];
    for (int i = 1; i < CAPACITY; i++) begin
      hit_seen[i] = hit_seen[i-1] | eq[i];
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_nxt[i] = cells_r[i];
    end
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    status_nxt    = status_r;
    element_nxt   = element_r;
    occ_nxt       = occ_r;
    last_nxt      = last_r;

    if (cmd.insert) begin
      out_valid_nxt = 1'b1;
      element_nxt   = in_value;
      last_nxt      = 1'b1;
      if (full) begin
        status_nxt = sli_pkg::ST_FULL;
        occ_nxt    = count_r;
      end else begin
        if (!lt[0]) begin
          cells_nxt[0] = in_value;
        end
        for (int i = 1; i < CAPACITY; i++) begin
          if (!lt[i]) begin
            if (lt[i-1]) begin
              cells_nxt[i] = in_value;
            end else begin
              cells_nxt[i] = cells_r[i-1];
            end
          end
        end
        count_nxt  = count_r + CW'(1);
        status_nxt = sli_pkg::ST_INSERTED;
        occ_nxt    = count_r + CW'(1);
      end
    end

    if (cmd.remove) begin
      out_valid_nxt = 1'b1;
      element_nxt   = in_value;
      last_nxt      = 1'b1;
      if (count_r == '0) begin
        status_nxt = sli_pkg::ST_EMPTY;
        occ_nxt    = '0;
      end else if (!found) begin
        status_nxt = sli_pkg::ST_NOT_FOUND;
        occ_nxt    = count_r;
      end else begin
        for (int i = 0; i < CAPACITY - 1; i++) begin
          if (hit_seen[i]) begin
            cells_nxt[i] = cells_r[i+1];
          end
        end
        count_nxt  = count_m1;
        status_nxt = sli_pkg::ST_DELETED;
        occ_nxt    = count_m1;
      end
    end

    if (cmd.dump_empty) begin
      out_valid_nxt = 1'b1;
      status_nxt    = sli_pkg::ST_EMPTY;
      element_nxt   = '0;
      occ_nxt       = '0;
      last_nxt      = 1'b1;
    end

    if (cmd.dump_step) begin
      out_valid_nxt = 1'b1;
      status_nxt    = sli_pkg::ST_LISTED;
      element_nxt   = cells_r[0];
      occ_nxt       = count_r;
      last_nxt      = dump_last;
      for (int i = 0; i < CAPACITY - 1; i++) begin
        cells_nxt[i] = cells_r[i+1];
      end
      for (int i = 0; i < CAPACITY; i++) begin
        if (CW'(i) == count_m1) begin
          cells_nxt[i] = cells_r[0];
        end
      end
      idx_nxt = dump_last ? '0 : idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_r[i] <= cells_nxt[i];
    end
    status_r  <= status_nxt;
    element_r <= element_nxt;
    occ_r     <= occ_nxt;
    last_r    <= last_nxt;
  end

  assign occ_ext     = {{sli_pkg::OCC_W{1'b0}}, occ_r};
  assign out_valid   = out_valid_r;
  assign out_status  = status_r;
  assign out_element = element_r;
  assign out_occ     = occ_ext[sli_pkg::OCC_W-1:0];
  assign out_last    = last_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("count above capacity");
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert && !full |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not grow the list");
  a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.insert || cmd.remove || cmd.dump_empty || cmd.dump_step) |-> sts.slot_free)
    else $error("result register overwritten");
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r == '0 || CW'(idx_r) < count_r)
    else $error("dump index beyond list");
`endif

endmodule

// File: design/sorted_list_insert_delete.sv
// Top level of the sorted list block: stream ports around sli_ctrl and sli_dpath.
// Depends on sli_pkg, sli_ctrl and sli_dpath.
//
//   channel  direction  tdata                         tuser        tlast
//   in_      slave      value[31:0]                   func[1:0]    -
//   out_     master     element[31:0], occupancy[36:32] status[2:0] last
//
// Insert and delete act on the shift-cell row directly; the result is registered.
// A dump gives one word per cycle, while the output is not stalled, for each stored value by rotating the cell row.
// The input is held off while a dump runs and while an unread result is stalled.
// Reset clears the count and the result valid; stored values need no reset.
module sorted_list_insert_delete #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sli_pkg::IN_DATA_W-1:0]     in_tdata,   // value[31:0]
  input  logic [sli_pkg::FUNC_W-1:0]        in_tuser,   // func[1:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sli_pkg::OUT_DATA_W-1:0]    out_tdata,  // element[31:0], occupancy[36:32]
  output logic [sli_pkg::STATUS_W-1:0]      out_tuser,  // status[2:0]
  output logic                              out_tlast
);

  sli_pkg::cmd_t                      cmd;
  sli_pkg::sts_t                      sts;
  logic signed [sli_pkg::VALUE_W-1:0] element;
  logic [sli_pkg::OCC_W-1:0]          occ;

  sli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_func   (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  sli_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_value    ($signed(in_tdata)),
    .cmd         (cmd),
    .sts         (sts),
    .out_tready  (out_tready),
    .out_valid   (out_tvalid),
    .out_status  (out_tuser),
    .out_element (element),
    .out_occ     (occ),
    .out_last    (out_tlast)
  );

  assign out_tdata = {3'b000, occ, element};

endmodule
